>>> rtl/song_segment_sequencer_assert.svh
// Assertion macros for the song segment sequencer.
// Every macro expects a clock named clk and a synchronous reset named rst in scope.
`ifndef SONG_SEGMENT_SEQUENCER_ASSERT_SVH
`define SONG_SEGMENT_SEQUENCER_ASSERT_SVH

// Condition must hold at every edge out of reset.
`define SSS_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) 1'b1 |-> (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define SSS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/sss_pkg.sv
// Shared types and constants of the song segment sequencer.
// No dependencies.
package sss_pkg;

  localparam int FUNC_W    = 2;
  localparam int SEG_IDX_W = 4;
  localparam int LEN_W     = 16;
  localparam int TICK_W    = 32;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK = 2'd0,
    FUNC_NEW  = 2'd1,
    FUNC_DEL  = 2'd2,
    FUNC_CLR  = 2'd3
  } func_t;

  typedef logic [SEG_IDX_W-1:0] seg_idx_t;
  typedef logic [LEN_W-1:0]     len_t;
  typedef logic [TICK_W-1:0]    tick_t;

  typedef struct packed {
    logic load;
    logic step;
    logic append;
    logic clear;
    logic shrink;
    logic emit;
  } cmd_t;

  typedef struct packed {
    func_t op;
    logic  del_hit;
    logic  ptr_end;
    logic  scan_done;
    logic  out_free;
  } status_t;

endpackage

>>> rtl/sss_req_if.sv
// Request channel of the song segment sequencer: valid/ready plus one operation.
// Depends on sss_pkg.
interface sss_req_if;
  logic              valid;
  logic              ready;
  sss_pkg::func_t    func;
  sss_pkg::seg_idx_t item_index;
  sss_pkg::len_t     length_ticks;

  modport source (output valid, output func, output item_index, output length_ticks,
                  input ready);
  modport sink   (input valid, input func, input item_index, input length_ticks,
                  output ready);
endinterface

>>> rtl/sss_rsp_if.sv
// Response channel of the song segment sequencer: valid/ready plus one result.
// Depends on sss_pkg.
interface sss_rsp_if;
  logic              valid;
  logic              ready;
  sss_pkg::seg_idx_t segment_index;
  logic              ok;

  modport source (output valid, output segment_index, output ok, input ready);
  modport sink   (input valid, input segment_index, input ok, output ready);
endinterface

>>> rtl/song_segment_sequencer.sv
// Top level of the song segment sequencer: controller plus datapath.
// Depends on sss_pkg, sss_req_if, sss_rsp_if, sss_ctrl, sss_datapath.
//
//   channel  dir   payload
//   req      in    func, item_index, length_ticks
//   rsp      out   segment_index, ok
//
// Active segments always form a prefix of the table; starts are running sums of lengths.
// Tick reads the n active segment lengths in turn (one length memory read per cycle);
// delete shifts the entries above item_index down by one place; new and clear go
// through their own state (S_NEW, S_CLR), and a missed delete goes straight to the result.
// Reset: n = 1, entry 0 length loaded during reset, no clearing pass.
// A held result on rsp does not block the next req transaction; it stalls only the
// final cycle of the following operation.
module song_segment_sequencer #(
  parameter int SEGMENTS       = 16,
  parameter int DEFAULT_LENGTH = 384
) (
  input logic  clk,
  input logic  rst,
  sss_req_if.sink   req,
  sss_rsp_if.source rsp
);
  import sss_pkg::*;

  cmd_t    cmd;
  status_t status;

  sss_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .status    (status),
    .cmd       (cmd)
  );

  sss_datapath #(
    .SEGMENTS       (SEGMENTS),
    .DEFAULT_LENGTH (DEFAULT_LENGTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .func          (req.func),
    .item_index    (req.item_index),
    .length_ticks  (req.length_ticks),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .segment_index (rsp.segment_index),
    .ok            (rsp.ok)
  );

endmodule

>>> rtl/sss_ctrl.sv
// Controller state machine of the song segment sequencer.
// Depends on sss_pkg; drives the datapath through cmd_t, observes status_t.
module sss_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  sss_pkg::status_t  status,
  output sss_pkg::cmd_t     cmd
);
  import sss_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_DISPATCH = 7'b0000010,
    S_SCAN     = 7'b0000100,
    S_SHIFT    = 7'b0001000,
    S_NEW      = 7'b0010000,
    S_CLR      = 7'b0100000,
    S_DONE     = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (status.op)
          FUNC_TICK: state_next = S_SCAN;
          FUNC_NEW:  state_next = S_NEW;
          FUNC_DEL:  state_next = status.del_hit ? S_SHIFT : S_DONE;
          FUNC_CLR:  state_next = S_CLR;
          default:   state_next = S_DONE;
        endcase
      end
      S_SCAN: begin
        cmd.step = !status.ptr_end;
        if (status.scan_done) begin
          state_next = S_DONE;
        end
      end
      S_SHIFT: begin
        cmd.step = !status.ptr_end;
        if (status.scan_done) begin
          cmd.shrink = 1'b1;
          state_next = S_DONE;
        end
      end
      S_NEW: begin
        cmd.append = 1'b1;
        state_next = S_DONE;
      end
      S_CLR: begin
        cmd.clear  = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> rtl/sss_datapath.sv
// Datapath of the song segment sequencer: length memory, active count, tick counter,
// running start sum and result register. Depends on sss_pkg and the assertion macros.
module sss_datapath #(
  parameter int SEGMENTS       = 16,
  parameter int DEFAULT_LENGTH = 384
) (
  input  logic              clk,
  input  logic              rst,
  input  sss_pkg::cmd_t     cmd,
  output sss_pkg::status_t  status,
  input  sss_pkg::func_t    func,
  input  sss_pkg::seg_idx_t item_index,
  input  sss_pkg::len_t     length_ticks,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output sss_pkg::seg_idx_t segment_index,
  output logic              ok
);
  import sss_pkg::*;

  `include "song_segment_sequencer_assert.svh"

  localparam int IDX_W = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
  localparam int CNT_W = $clog2(SEGMENTS + 1);
  localparam int CMP_W = (CNT_W > SEG_IDX_W) ? CNT_W : SEG_IDX_W;

  len_t               mem [SEGMENTS];
  len_t               rd_data;
  logic               acc_v;
  logic [IDX_W-1:0]   acc_idx;
  logic [CNT_W-1:0]   n;
  logic [CNT_W-1:0]   ptr;
  tick_t              tick;
  len_t               sum;
  func_t              op;
  seg_idx_t           idx_q;
  len_t               len_q;
  seg_idx_t           res_idx;
  logic               res_ok;
  logic               full;

  assign full             = (n == CNT_W'(SEGMENTS));
  assign status.op        = op;
  assign status.del_hit   = CMP_W'(idx_q) < CMP_W'(n);
  assign status.ptr_end   = (ptr >= n);
  assign status.scan_done = (ptr >= n) && !acc_v;
  assign status.out_free  = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      mem[0] <= LEN_W'(DEFAULT_LENGTH);
    end else if (cmd.append && !full) begin
      mem[n[IDX_W-1:0]] <= len_q;
    end else if (acc_v && op == FUNC_DEL) begin
      mem[acc_idx - IDX_W'(1)] <= rd_data;
    end
    if (cmd.step) begin
      rd_data <= mem[ptr[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n         <= CNT_W'(1);
      ptr       <= '0;
      acc_v     <= 1'b0;
      tick      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      acc_v <= cmd.step;
      if (cmd.load) begin
        if (func == FUNC_TICK) begin
          tick <= tick + TICK_W'(1);
        end
        ptr <= (func == FUNC_DEL) ? CNT_W'(item_index) + CNT_W'(1) : '0;
      end else if (cmd.step) begin
        ptr <= ptr + CNT_W'(1);
      end
      priority if (cmd.clear) begin
        n <= CNT_W'(1);
      end else if (cmd.append && !full) begin
        n <= n + CNT_W'(1);
      end else if (cmd.shrink) begin
        n <= n - CNT_W'(1);
      end
      if (cmd.emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      acc_idx <= ptr[IDX_W-1:0];
    end
    if (cmd.load) begin
      op      <= func;
      idx_q   <= item_index;
      len_q   <= length_ticks;
      sum     <= '0;
      res_idx <= '0;
      res_ok  <= 1'b1;
    end else begin
      if (acc_v && op == FUNC_TICK) begin
        if (acc_idx != '0 && TICK_W'(sum) <= tick) begin
          res_idx <= seg_idx_t'(acc_idx);
        end
        sum <= sum + rd_data;
      end
      if (cmd.append) begin
        if (full) begin
          res_ok <= 1'b0;
        end else begin
          res_idx <= seg_idx_t'(n);
        end
      end
    end
    if (cmd.emit) begin
      segment_index <= res_idx;
      ok            <= res_ok;
    end
  end

  `SSS_ASSERT_ALWAYS(a_count_range, n <= CNT_W'(SEGMENTS), "active count above table size")
  `SSS_ASSERT_IMPL(a_step_in_range, cmd.step, ptr < n, "read beyond active entries")
  `SSS_ASSERT_NEXT(a_append_grows, cmd.append && !full, n == $past(n) + CNT_W'(1), "append lost")
  `SSS_ASSERT_IMPL(a_emit_free, cmd.emit, !rsp_valid || rsp_ready, "result overwritten")

endmodule
